// ----- src/rgb565_box_downscale_core_assert.svh -----
// assertion macros for the box downscaler
`ifndef RGB565_BOX_DOWNSCALE_CORE_ASSERT_SVH
`define RGB565_BOX_DOWNSCALE_CORE_ASSERT_SVH
`define RBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- src/rbd_pkg.sv -----
package rbd_pkg;
    localparam int MAX_SRC_WIDTH_DEF  = 512;
    localparam int MAX_SRC_HEIGHT_DEF = 512;
    localparam int STEP_W  = 24;
    localparam int ORG_W   = 32;
    localparam int SIZE_W  = 10;
    localparam int COORD_W = 12;
    localparam int PIX_W   = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;
    localparam logic [2:0] REG_STEP     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
    localparam logic [2:0] REG_SRC_W    = 3'd3;
    localparam logic [2:0] REG_SRC_H    = 3'd4;
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAPX, ST_MAPY, ST_SPAN, ST_READ, ST_DIV, ST_DONE
    } t_state;

    // mapping request to the span unit
    typedef struct packed {
        logic               go;
        logic [COORD_W-1:0] coord;
        logic [ORG_W-1:0]   origin;
        logic [12:0]        limit;
    } t_span_req;

    typedef struct packed {
        logic               done;
        logic signed [33:0] lo;
        logic signed [33:0] hi;
    } t_span_rsp;
endpackage

// ----- src/rbd_span.sv -----
// one axis: s0 = d*step, lo = trunc(s0), hi = trunc(s0+step<<16+0.5), clamped
module rbd_span (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [rbd_pkg::STEP_W-1:0] i_step,
    input  rbd_pkg::t_span_req    i_req,
    output rbd_pkg::t_span_rsp    o_rsp
);
    logic signed [33:0] r_d;
    logic signed [24:0] r_st;
    logic signed [59:0] r_plo, r_phi, n_plo, n_phi;
    logic signed [59:0] r_s0;
    logic signed [12:0] r_lim;
    logic [2:0]         r_ph;
    logic signed [33:0] r_a, r_e, n_a, n_e;
    logic signed [59:0] v1;
    logic               take;

    // a new request is taken while idle or in the done cycle
    assign take = i_req.go && ((r_ph == 3'd0) || (r_ph == 3'd5));

    // 34x25 product split into two 17-bit partial products, the low one registered first, then the high one
    always_comb begin
        n_plo = $signed({1'b0, r_d[16:0]}) * r_st;   // low digits, unsigned
        n_phi = $signed(r_d[33:17]) * r_st;          // high digits, signed
        v1 = r_s0 + ($signed({1'b0, r_st}) <<< 16) + (60'sd1 <<< 31);
        n_a = (r_s0 >= 0) ? 34'(r_s0 >>> 32) : -34'((-r_s0) >>> 32);
        n_e = (v1 >= 0) ? 34'(v1 >>> 32) : -34'((-v1) >>> 32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 3'd0;
        end else begin
            case (r_ph)
                3'd0: if (take) r_ph <= 3'd1;
                3'd1: r_ph <= 3'd2;
                3'd2: r_ph <= 3'd3;
                3'd3: r_ph <= 3'd4;
                3'd4: r_ph <= 3'd5;
                default: r_ph <= take ? 3'd1 : 3'd0;
            endcase
        end
        if (take) begin
            r_d   <= ($signed({22'd0, i_req.coord}) <<< 16)
                     - 34'($signed(i_req.origin));
            r_st  <= $signed({1'b0, i_step});
            r_lim <= $signed(i_req.limit);
        end
        case (r_ph)
            3'd1: r_plo <= n_plo;
            3'd2: r_phi <= n_phi;
            3'd3: r_s0 <= (r_phi <<< 17) + r_plo;
            3'd4: begin
                r_a <= n_a;
                r_e <= (n_e <= n_a) ? n_a + 34'sd1 : n_e;
            end
            3'd5: begin
                if (r_a < 0) r_a <= '0;
                if (r_e > 34'(r_lim)) r_e <= 34'(r_lim);
            end
            default: ;
        endcase
    end

    assign o_rsp.done = (r_ph == 3'd5);
    assign o_rsp.lo   = (r_ph == 3'd5) ? ((r_a < 0) ? 34'sd0 : r_a) : r_a;
    assign o_rsp.hi   = (r_ph == 3'd5) ? ((r_e > 34'(r_lim)) ? 34'(r_lim) : r_e) : r_e;
endmodule

// ----- src/rbd_div.sv -----
// restoring divider, one quotient bit per cycle, three channels together
module rbd_div #(
    parameter int NW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_r,
    input  logic [NW-1:0] i_g,
    input  logic [NW-1:0] i_b,
    input  logic [NW-1:0] i_n,
    output logic          o_done,
    output logic [15:0]   o_pix
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_qr, r_qg, r_qb, r_n;
    logic [NW:0]   r_rr, r_rg, r_rb;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [NW:0]   tr, tg, tb;

    always_comb begin
        tr = {r_rr[NW-1:0], r_qr[NW-1]};
        tg = {r_rg[NW-1:0], r_qg[NW-1]};
        tb = {r_rb[NW-1:0], r_qb[NW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_qr <= i_r; r_qg <= i_g; r_qb <= i_b; r_n <= i_n;
                r_rr <= '0; r_rg <= '0; r_rb <= '0;
            end else if (r_busy) begin
                if (tr >= {1'b0, r_n}) begin
                    r_rr <= tr - {1'b0, r_n}; r_qr <= {r_qr[NW-2:0], 1'b1};
                end else begin
                    r_rr <= tr; r_qr <= {r_qr[NW-2:0], 1'b0};
                end
                if (tg >= {1'b0, r_n}) begin
                    r_rg <= tg - {1'b0, r_n}; r_qg <= {r_qg[NW-2:0], 1'b1};
                end else begin
                    r_rg <= tg; r_qg <= {r_qg[NW-2:0], 1'b0};
                end
                if (tb >= {1'b0, r_n}) begin
                    r_rb <= tb - {1'b0, r_n}; r_qb <= {r_qb[NW-2:0], 1'b1};
                end else begin
                    r_rb <= tb; r_qb <= {r_qb[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_pix  = {r_qr[4:0], r_qg[5:0], r_qb[4:0]};
endmodule

// ----- src/rgb565_box_downscale_core.sv -----
// load: busy stays low; a load may follow every cycle
// sample: box mapping (two span passes, x then y), one store read per box pixel, drain
//   of the read data, then the divider; the strobe follows the divider's done flag,
//   next transfer at the edge that ends the strobe
// empty box: strobe with no store reads; the receiver cannot stall
// reset: synchronous active low, clears control and configuration registers; store is not cleared
module rgb565_box_downscale_core #(
    parameter int MAX_SRC_WIDTH  = rbd_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = rbd_pkg::MAX_SRC_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_opcode,
    input  logic [11:0] i_coord_x,
    input  logic [11:0] i_coord_y,
    input  logic [15:0] i_pixel_in,
    output logic        o_valid,
    output logic [15:0] o_pixel_out,
    output logic        o_empty_box
);
    localparam int XW  = $clog2(MAX_SRC_WIDTH);
    localparam int YW  = $clog2(MAX_SRC_HEIGHT);
    localparam int AW  = XW + YW;
    // row and column bits are concatenated, so the store spans the full address range
    localparam int DEP = 1 << AW;
    // sums: 6 bits per pixel times up to MAX_SRC_WIDTH*MAX_SRC_HEIGHT pixels
    localparam int NW  = 32;

    // configuration registers
    logic [23:0] r_step;
    logic [31:0] r_org_x, r_org_y;
    logic [9:0]  r_src_w, r_src_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= rbd_pkg::STEP_RESET;
            r_org_x <= '0;
            r_org_y <= '0;
            r_src_w <= rbd_pkg::SIZE_RESET;
            r_src_h <= rbd_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rbd_pkg::REG_STEP:     r_step  <= i_cfg_data[23:0];
                rbd_pkg::REG_ORIGIN_X: r_org_x <= i_cfg_data;
                rbd_pkg::REG_ORIGIN_Y: r_org_y <= i_cfg_data;
                rbd_pkg::REG_SRC_W:    r_src_w <= i_cfg_data[9:0];
                rbd_pkg::REG_SRC_H:    r_src_h <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // source size saturated to the store size
    logic [12:0] lim_w, lim_h;
    assign lim_w = ({3'd0, r_src_w} > 13'(MAX_SRC_WIDTH))  ? 13'(MAX_SRC_WIDTH)  : {3'd0, r_src_w};
    assign lim_h = ({3'd0, r_src_h} > 13'(MAX_SRC_HEIGHT)) ? 13'(MAX_SRC_HEIGHT) : {3'd0, r_src_h};

    // image store, one write or one read per cycle
    logic [15:0] mem [DEP];
    logic [15:0] r_rdata;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= i_pixel_in;
        if (mem_re) r_rdata <= mem[mem_ra];
    end

    // sequencer
    rbd_pkg::t_state r_st, n_st;
    rbd_pkg::t_span_req span_req;
    rbd_pkg::t_span_rsp span_rsp;
    logic [11:0] r_cx, r_cy;
    logic signed [33:0] r_x0, r_x1, r_y1;
    logic [12:0] r_sx, r_sy;
    logic        r_rv;        // read data valid this cycle
    logic        r_last;      // final read issued
    logic [NW-1:0] r_sr, r_sg, r_sb, r_n;
    logic        div_go, div_done;
    logic [15:0] div_pix;
    logic        r_ov, r_oe;
    logic [15:0] r_op;
    logic        issue, lastx, lasty;

    rbd_span u_span (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(r_step),
        .i_req(span_req), .o_rsp(span_rsp)
    );

    rbd_div #(.NW(NW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(div_go),
        .i_r(r_sr), .i_g(r_sg), .i_b(r_sb), .i_n(r_n),
        .o_done(div_done), .o_pix(div_pix)
    );

    assign lastx = (34'($signed({1'b0, r_sx})) + 34'sd1 >= r_x1);
    assign lasty = (34'($signed({1'b0, r_sy})) + 34'sd1 >= r_y1);
    assign issue = (r_st == rbd_pkg::ST_READ) && !r_last;
    assign mem_ra = {r_sy[YW-1:0], r_sx[XW-1:0]};
    assign mem_re = issue;
    // loads outside the store are dropped
    assign mem_we = start && !busy && (i_opcode == rbd_pkg::OP_LOAD)
                    && ({1'b0, i_coord_x} < 13'(MAX_SRC_WIDTH))
                    && ({1'b0, i_coord_y} < 13'(MAX_SRC_HEIGHT));
    assign mem_wa = {i_coord_y[YW-1:0], i_coord_x[XW-1:0]};

    always_comb begin
        n_st = r_st;
        span_req.go = 1'b0;
        span_req.coord = r_cx;
        span_req.origin = r_org_x;
        span_req.limit = lim_w;
        div_go = 1'b0;
        case (r_st)
            rbd_pkg::ST_IDLE: if (start && i_opcode == rbd_pkg::OP_SAMPLE) n_st = rbd_pkg::ST_MAPX;
            rbd_pkg::ST_MAPX: begin
                span_req.go = 1'b1;
                n_st = rbd_pkg::ST_MAPY;
            end
            rbd_pkg::ST_MAPY: if (span_rsp.done) begin
                span_req.go = 1'b1;
                span_req.coord = r_cy;
                span_req.origin = r_org_y;
                span_req.limit = lim_h;
                n_st = rbd_pkg::ST_SPAN;
            end
            rbd_pkg::ST_SPAN: if (span_rsp.done) begin
                if (span_rsp.hi <= span_rsp.lo || r_x1 <= r_x0) n_st = rbd_pkg::ST_DONE;
                else n_st = rbd_pkg::ST_READ;
            end
            rbd_pkg::ST_READ: if (r_last && !r_rv) begin
                div_go = 1'b1;
                n_st = rbd_pkg::ST_DIV;
            end
            rbd_pkg::ST_DIV: if (div_done) n_st = rbd_pkg::ST_IDLE;
            rbd_pkg::ST_DONE: n_st = rbd_pkg::ST_IDLE;
            default: n_st = rbd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rbd_pkg::ST_IDLE;
            r_rv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_rv <= issue;
            r_ov <= 1'b0;
            if (r_st == rbd_pkg::ST_DONE) begin
                r_ov <= 1'b1; r_oe <= 1'b1; r_op <= '0;
            end else if (r_st == rbd_pkg::ST_DIV && div_done) begin
                r_ov <= 1'b1; r_oe <= 1'b0; r_op <= div_pix;
            end
        end
        if (r_st == rbd_pkg::ST_IDLE) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
        end
        if (r_st == rbd_pkg::ST_MAPY && span_rsp.done) begin
            r_x0 <= span_rsp.lo; r_x1 <= span_rsp.hi;
        end
        if (r_st == rbd_pkg::ST_SPAN && span_rsp.done) begin
            r_y1 <= span_rsp.hi;
            r_sx <= span_rsp.hi > span_rsp.lo ? r_x0[12:0] : r_x0[12:0];
            r_sy <= span_rsp.lo[12:0];
            r_last <= 1'b0;
            r_sr <= '0; r_sg <= '0; r_sb <= '0; r_n <= '0;
        end
        // walk the box row by row
        if (issue) begin
            if (lastx) begin
                r_sx <= r_x0[12:0];
                if (lasty) r_last <= 1'b1;
                else r_sy <= r_sy + 13'd1;
            end else begin
                r_sx <= r_sx + 13'd1;
            end
        end
        // accumulate the channels as read data returns
        if (r_rv) begin
            r_sr <= r_sr + NW'(r_rdata[15:11]);
            r_sg <= r_sg + NW'(r_rdata[10:5]);
            r_sb <= r_sb + NW'(r_rdata[4:0]);
            r_n  <= r_n + NW'(1);
        end
    end

    assign busy        = (r_st != rbd_pkg::ST_IDLE);
    assign o_valid     = r_ov;
    assign o_pixel_out = r_op;
    assign o_empty_box = r_oe;
endmodule

// ----- src/rbd_checker.sv -----
`include "rgb565_box_downscale_core_assert.svh"
module rbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_opcode,
    input logic        o_valid,
    input logic [15:0] o_pixel_out,
    input logic        o_empty_box
);
    `RBD_ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, o_valid && o_empty_box, o_pixel_out == 16'd0, "empty box with nonzero pixel")
    `RBD_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, start && !busy && i_opcode, busy, "sample not taken")
    `RBD_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, start && !busy && !i_opcode, !busy && !o_valid, "load made busy")
    `RBD_ASSERT_IMPL(a_valid_busy, i_clk, i_rst_n, o_valid, !$past(o_valid), "double result")
endmodule

bind rgb565_box_downscale_core rbd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_opcode(i_opcode),
    .o_valid(o_valid), .o_pixel_out(o_pixel_out), .o_empty_box(o_empty_box)
);
